### sv/lsfit_pkg.sv
package lsfit_pkg;

  localparam int DEF_MAX_POINTS  = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Result format: signed Q31.16, saturated.
  localparam int OUT_BITS    = 48;
  localparam int FRAC_BITS   = 16;
  localparam int STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    FS_OK         = 2'd0,
    FS_TOO_FEW    = 2'd1,
    FS_DEGENERATE = 2'd2,
    FS_TOO_MANY   = 2'd3
  } fit_status_t;

endpackage

### sv/least_squares_line_fit.sv
// Least-squares line fit over a stream of calibration points. Each input transfer carries
// one point (x_sample, y_sample); the block keeps the point count and the running sums of
// x, y, x*y and x*x over at most MAX_POINTS points (later points are dropped and flagged).
// On the transfer marked with in_tlast the point is added first, then the block fits
// y = a*x + b, or y = k*x when fit_through_origin is set, delivers one result transfer
// (slope and intercept in signed Q31.16, rounded half away from zero and saturated, plus a
// status code on out_tuser) and clears its sums. All products come from one bit-serial
// shift-and-add multiplier that retires one multiplier bit per cycle, and both quotients
// come from one restoring divider that retires one quotient bit per cycle. A point that
// is counted occupies the block for two serial products, x*y and x*x, of SAMPLE_BITS
// steps each, and the input channel takes no new point until both are done.
// With OW = 2*SAMPLE_BITS+clog2(MAX_POINTS+1)-1 and NW = 2*OW+17, a line fit runs six
// serial products of OW steps each and two divisions of NW steps each after the last
// point, and an origin fit runs one division of NW steps. A point or a fit may start
// while the previous result still waits on the output register; a finished fit waits
// there until that register is free. The configuration write channel is always ready
// and should only be written while the block is idle.
module least_squares_line_fit #(
  parameter int MAX_POINTS  = lsfit_pkg::DEF_MAX_POINTS,
  parameter int SAMPLE_BITS = lsfit_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Calibration point channel.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0 up: x_sample, y_sample, zero padding to whole bytes.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                   in_tlast,   // last_point
  // Fit result channel.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0 up: slope, intercept.
  output logic [2*lsfit_pkg::OUT_BITS-1:0]       out_tdata,
  // Fields from bit 0 up: fit_status.
  output logic [lsfit_pkg::STATUS_BITS-1:0]      out_tuser,
  // Configuration write channel: fit_through_origin.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [0:0]                             cfg_data
);
  import lsfit_pkg::*;

  // Widths of the accumulators and of the fit datapath.
  localparam int CW  = $clog2(MAX_POINTS + 1);       // point count
  localparam int SXW = SAMPLE_BITS + CW;             // sum of x, sum of y
  localparam int SPW = 2*SAMPLE_BITS + CW - 1;       // sum of x*y, sum of x*x
  localparam int OW  = SPW;                          // common multiplier operand width
  localparam int PW  = 2*OW + 1;                     // difference of two products
  localparam int NW  = PW + FRAC_BITS;               // scaled dividend
  localparam int RW  = PW + 1;                       // divider remainder
  localparam int BCW = $clog2(OW);
  localparam int DCW = $clog2(NW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PXY,
    S_PXX,
    S_FIT,
    S_MUL,
    S_DCHK,
    S_PREP1,
    S_PREP2,
    S_DIV,
    S_DIV_END,
    S_FINISH
  } state_t;

  // Serial products, taken in pairs: the even one is added, the odd one subtracted.
  typedef enum logic [2:0] {
    MOP_NSXX,     // n * Sxx
    MOP_SXSX,     // Sx * Sx
    MOP_NSXY,     // n * Sxy
    MOP_SXSY,     // Sx * Sy
    MOP_SYSXX,    // Sy * Sxx
    MOP_SXSXY     // Sx * Sxy
  } mul_op_t;

  state_t                  state_r;
  logic                    fit_origin_r;
  logic                    out_valid_r;
  logic [OUT_BITS-1:0]     out_slope_r;
  logic [OUT_BITS-1:0]     out_icpt_r;
  fit_status_t             out_status_r;

  // Running sums.
  logic [CW-1:0]           cnt_r;
  logic [SXW-1:0]          sx_r;
  logic [SXW-1:0]          sy_r;
  logic [SPW-1:0]          sxy_r;
  logic [SPW-1:0]          sxx_r;
  logic                    ovf_r;
  logic                    last_r;
  logic [SAMPLE_BITS-1:0]  x_r;

  // Serial multiplier.
  logic [PW-1:0]           acc_r;
  logic [PW-1:0]           acc_nxt;
  logic [PW-1:0]           mcand_r;
  logic [OW-1:0]           mplier_r;
  logic [BCW-1:0]          bit_r;
  logic                    sub_r;
  mul_op_t                 op_r;

  // Fit operands and divider.
  logic [PW-1:0]           num_r;
  logic [PW-1:0]           den_r;
  logic [PW-1:0]           den_mag_r;
  logic [NW-1:0]           div_n_r;
  logic [RW-1:0]           rem_r;
  logic [RW-1:0]           rem_nxt;
  logic [OUT_BITS-1:0]     q_r;
  logic                    q_sticky_r;
  logic [DCW-1:0]          div_cnt_r;
  logic                    neg_r;
  logic                    div_icpt_r;
  logic [OUT_BITS-1:0]     slope_r;
  logic [OUT_BITS-1:0]     icpt_r;
  fit_status_t             status_r;

  logic                    in_accept;
  logic                    counted;
  logic [SAMPLE_BITS-1:0]  x_in;
  logic [SAMPLE_BITS-1:0]  y_in;
  logic                    mac_last;
  logic                    mac_sub;
  int                      mac_len;
  mul_op_t                 op_ld;
  logic [OW-1:0]           ld_mcand;
  logic [OW-1:0]           ld_mplier;
  logic                    ld_sub;
  logic [PW-1:0]           ld_mcand_ext;
  logic [OW-1:0]           n_ext;
  logic [OW-1:0]           sx_ext;
  logic [OW-1:0]           sy_ext;
  logic [PW-1:0]           num_mag;
  logic [PW-1:0]           den_mag;
  logic [RW-1:0]           r_sh;
  logic [RW-1:0]           d_ext;
  logic                    q_bit;
  logic [OUT_BITS-1:0]     sat_lim;
  logic [OUT_BITS-1:0]     sat_mag;
  logic [OUT_BITS-1:0]     fix_res;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_icpt_r, out_slope_r};
  assign out_tuser  = out_status_r;

  assign x_in    = in_tdata[SAMPLE_BITS-1:0];
  assign y_in    = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign counted = (cnt_r < CW'(MAX_POINTS));

  assign n_ext  = {{(OW-CW){1'b0}}, cnt_r};
  assign sx_ext = {{(OW-SXW){sx_r[SXW-1]}}, sx_r};
  assign sy_ext = {{(OW-SXW){sy_r[SXW-1]}}, sy_r};

  // Shift-and-add step. The multiplier is two's complement, so its top bit has
  // negative weight and flips the direction of that last add.
  always_comb begin
    mac_len  = ((state_r == S_PXY) || (state_r == S_PXX)) ? SAMPLE_BITS : OW;
    mac_last = (bit_r == BCW'(mac_len - 1));
    mac_sub  = sub_r ^ mac_last;
    if (!mplier_r[0]) begin
      acc_nxt = acc_r;
    end else if (mac_sub) begin
      acc_nxt = acc_r - mcand_r;
    end else begin
      acc_nxt = acc_r + mcand_r;
    end
  end

  // Operands of the next serial product of a fit.
  always_comb begin
    case (state_r)
      S_FIT:     op_ld = MOP_NSXX;
      S_DCHK:    op_ld = MOP_NSXY;
      S_DIV_END: op_ld = MOP_SYSXX;
      default:   op_ld = mul_op_t'(op_r + 3'd1);
    endcase
    ld_sub = (op_ld == MOP_SXSX) || (op_ld == MOP_SXSY) || (op_ld == MOP_SXSXY);
    case (op_ld)
      MOP_NSXX: begin
        ld_mcand  = sxx_r;
        ld_mplier = n_ext;
      end
      MOP_SXSX: begin
        ld_mcand  = sx_ext;
        ld_mplier = sx_ext;
      end
      MOP_NSXY: begin
        ld_mcand  = sxy_r;
        ld_mplier = n_ext;
      end
      MOP_SXSY: begin
        ld_mcand  = sy_ext;
        ld_mplier = sx_ext;
      end
      MOP_SYSXX: begin
        ld_mcand  = sxx_r;
        ld_mplier = sy_ext;
      end
      MOP_SXSXY: begin
        ld_mcand  = sxy_r;
        ld_mplier = sx_ext;
      end
      default: begin
        ld_mcand  = '0;
        ld_mplier = '0;
      end
    endcase
    ld_mcand_ext = {{(PW-OW){ld_mcand[OW-1]}}, ld_mcand};
  end

  // Divider: one restoring step per cycle, magnitudes only.
  always_comb begin
    num_mag = num_r[PW-1] ? (~num_r + 1'b1) : num_r;
    den_mag = den_r[PW-1] ? (~den_r + 1'b1) : den_r;
    r_sh    = {rem_r[RW-2:0], div_n_r[NW-1]};
    d_ext   = {1'b0, den_mag_r};
    q_bit   = (r_sh >= d_ext);
    rem_nxt = q_bit ? (r_sh - d_ext) : r_sh;
  end

  // Saturation to the signed output range, then the sign of the quotient.
  always_comb begin
    sat_lim = neg_r ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
    sat_mag = (q_sticky_r || (q_r > sat_lim)) ? sat_lim : q_r;
    fix_res = neg_r ? (~sat_mag + 1'b1) : sat_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fit_origin_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      sx_r         <= '0;
      sy_r         <= '0;
      sxy_r        <= '0;
      sxx_r        <= '0;
      ovf_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fit_origin_r <= cfg_data[0];
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            last_r <= in_tlast;
            x_r    <= x_in;
            if (counted) begin
              // The linear sums go in at once; the two products follow serially.
              sx_r     <= sx_r + {{(SXW-SAMPLE_BITS){x_in[SAMPLE_BITS-1]}}, x_in};
              sy_r     <= sy_r + {{(SXW-SAMPLE_BITS){y_in[SAMPLE_BITS-1]}}, y_in};
              cnt_r    <= cnt_r + 1'b1;
              acc_r    <= {{(PW-SPW){sxy_r[SPW-1]}}, sxy_r};
              mcand_r  <= {{(PW-SAMPLE_BITS){x_in[SAMPLE_BITS-1]}}, x_in};
              mplier_r <= {{(OW-SAMPLE_BITS){y_in[SAMPLE_BITS-1]}}, y_in};
              sub_r    <= 1'b0;
              bit_r    <= '0;
              state_r  <= S_PXY;
            end else begin
              ovf_r <= 1'b1;
              if (in_tlast) begin
                state_r <= S_FIT;
              end
            end
          end
        end

        S_PXY: begin
          acc_r    <= acc_nxt;
          mcand_r  <= {mcand_r[PW-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[OW-1:1]};
          bit_r    <= bit_r + 1'b1;
          if (mac_last) begin
            sxy_r    <= acc_nxt[SPW-1:0];
            acc_r    <= {{(PW-SPW){sxx_r[SPW-1]}}, sxx_r};
            mcand_r  <= {{(PW-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
            mplier_r <= {{(OW-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
            bit_r    <= '0;
            state_r  <= S_PXX;
          end
        end

        S_PXX: begin
          acc_r    <= acc_nxt;
          mcand_r  <= {mcand_r[PW-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[OW-1:1]};
          bit_r    <= bit_r + 1'b1;
          if (mac_last) begin
            sxx_r   <= acc_nxt[SPW-1:0];
            state_r <= last_r ? S_FIT : S_IDLE;
          end
        end

        S_FIT: begin
          slope_r    <= '0;
          icpt_r     <= '0;
          status_r   <= FS_OK;
          div_icpt_r <= 1'b0;
          if (fit_origin_r) begin
            if (cnt_r == '0) begin
              status_r <= FS_TOO_FEW;
              state_r  <= S_FINISH;
            end else if (sxx_r == '0) begin
              status_r <= FS_DEGENERATE;
              state_r  <= S_FINISH;
            end else begin
              num_r   <= {{(PW-SPW){sxy_r[SPW-1]}}, sxy_r};
              den_r   <= {{(PW-SPW){sxx_r[SPW-1]}}, sxx_r};
              state_r <= S_PREP1;
            end
          end else if (cnt_r < CW'(2)) begin
            status_r <= FS_TOO_FEW;
            state_r  <= S_FINISH;
          end else begin
            acc_r    <= '0;
            mcand_r  <= ld_mcand_ext;
            mplier_r <= ld_mplier;
            sub_r    <= ld_sub;
            op_r     <= op_ld;
            bit_r    <= '0;
            state_r  <= S_MUL;
          end
        end

        S_MUL: begin
          acc_r    <= acc_nxt;
          mcand_r  <= {mcand_r[PW-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[OW-1:1]};
          bit_r    <= bit_r + 1'b1;
          if (mac_last) begin
            bit_r <= '0;
            case (op_r)
              MOP_SXSX: begin
                den_r   <= acc_nxt;
                state_r <= S_DCHK;
              end
              MOP_SXSY: begin
                num_r      <= acc_nxt;
                div_icpt_r <= 1'b0;
                state_r    <= S_PREP1;
              end
              MOP_SXSXY: begin
                num_r      <= acc_nxt;
                div_icpt_r <= 1'b1;
                state_r    <= S_PREP1;
              end
              default: begin
                // First product of a pair done: the second one accumulates on top.
                mcand_r  <= ld_mcand_ext;
                mplier_r <= ld_mplier;
                sub_r    <= ld_sub;
                op_r     <= op_ld;
              end
            endcase
          end
        end

        S_DCHK: begin
          if (den_r == '0) begin
            status_r <= FS_DEGENERATE;
            state_r  <= S_FINISH;
          end else begin
            acc_r    <= '0;
            mcand_r  <= ld_mcand_ext;
            mplier_r <= ld_mplier;
            sub_r    <= ld_sub;
            op_r     <= op_ld;
            bit_r    <= '0;
            state_r  <= S_MUL;
          end
        end

        S_PREP1: begin
          div_n_r   <= {num_mag, {FRAC_BITS{1'b0}}};
          den_mag_r <= den_mag;
          neg_r     <= num_r[PW-1] ^ den_r[PW-1];
          state_r   <= S_PREP2;
        end

        S_PREP2: begin
          // Adding half the divisor rounds the truncating division to nearest.
          div_n_r    <= div_n_r + {{(NW-PW+1){1'b0}}, den_mag_r[PW-1:1]};
          rem_r      <= '0;
          q_r        <= '0;
          q_sticky_r <= 1'b0;
          div_cnt_r  <= '0;
          state_r    <= S_DIV;
        end

        S_DIV: begin
          rem_r      <= rem_nxt;
          div_n_r    <= {div_n_r[NW-2:0], 1'b0};
          q_r        <= {q_r[OUT_BITS-2:0], q_bit};
          q_sticky_r <= q_sticky_r | q_r[OUT_BITS-1];
          div_cnt_r  <= div_cnt_r + 1'b1;
          if (div_cnt_r == DCW'(NW - 1)) begin
            state_r <= S_DIV_END;
          end
        end

        S_DIV_END: begin
          if (div_icpt_r) begin
            icpt_r  <= fix_res;
            state_r <= S_FINISH;
          end else begin
            slope_r <= fix_res;
            if (fit_origin_r) begin
              state_r <= S_FINISH;
            end else begin
              acc_r    <= '0;
              mcand_r  <= ld_mcand_ext;
              mplier_r <= ld_mplier;
              sub_r    <= ld_sub;
              op_r     <= op_ld;
              bit_r    <= '0;
              state_r  <= S_MUL;
            end
          end
        end

        S_FINISH: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_slope_r  <= slope_r;
            out_icpt_r   <= icpt_r;
            out_status_r <= ((status_r == FS_OK) && ovf_r) ? FS_TOO_MANY : status_r;
            cnt_r        <= '0;
            sx_r         <= '0;
            sy_r         <= '0;
            sxy_r        <= '0;
            sxx_r        <= '0;
            ovf_r        <= 1'b0;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The point count never runs past the limit; extra points only raise the flag.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count above MAX_POINTS");

  // A failed fit reports zero slope and zero intercept.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((out_tuser == FS_TOO_FEW) || (out_tuser == FS_DEGENERATE)))
      |-> (out_tdata == '0))
    else $error("failed fit with nonzero result");

  // In origin mode the intercept is always zero.
  a_origin_icpt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && fit_origin_r) |-> (out_tdata[2*OUT_BITS-1:OUT_BITS] == '0))
    else $error("nonzero intercept in origin mode");

  // The partial remainder stays below the divisor throughout a division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < {1'b0, den_mag_r}))
    else $error("divider remainder not below divisor");
`endif

endmodule

### tb/tb_least_squares_line_fit.sv
module tb_least_squares_line_fit;
  import lsfit_pkg::*;

  localparam int MAX_PTS       = DEF_MAX_POINTS;
  localparam int CYCLE_LIMIT   = 10_000_000;
  // A counted point keeps the block busy for two serial products, so this is enough
  // for a trailing non-last point to settle before the mode register changes.
  localparam int POINT_SETTLE  = 100;
  localparam int END_SETTLE    = 1000;
  localparam int RANDOM_POINTS = 350;
  localparam int RANDOM_PHASES = 14;

  localparam logic signed [15:0] S_MIN = 16'sh8000;
  localparam logic signed [15:0] S_MAX = 16'sh7fff;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] slope;
    logic signed [OUT_BITS-1:0] intercept;
    fit_status_t                status;
  } fit_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data   = 1'b0;

  // Shadow copy of the block's accumulators and mode, updated on every transfer.
  bit          fit_origin   = 1'b0;
  int unsigned pt_count     = 0;
  longint      sum_x        = 0;
  longint      sum_y        = 0;
  longint      sum_xy       = 0;
  longint      sum_xx       = 0;
  bit          pts_dropped  = 1'b0;
  fit_result_t pending_fits[$];

  int     errors      = 0;
  bit     calm        = 1'b0;
  int     hold_request = 0;
  int     hold_left   = 0;
  int     stall_left  = 0;
  longint cycle_count = 0;

  least_squares_line_fit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // round(num * 2^16 / den), half away from zero, saturated to the output width.
  function automatic logic [OUT_BITS-1:0] q16_quotient(logic signed [127:0] num,
                                                       logic signed [127:0] den);
    logic [127:0] num_mag;
    logic [127:0] den_mag;
    logic [127:0] quo;
    logic [127:0] lim;
    bit           neg;
    neg     = num[127] ^ den[127];
    num_mag = num[127] ? -num : num;
    den_mag = den[127] ? -den : den;
    quo     = ((num_mag << FRAC_BITS) + (den_mag >> 1)) / den_mag;
    lim     = (128'd1 << (OUT_BITS - 1)) - (neg ? 128'd0 : 128'd1);
    if (quo > lim) quo = lim;
    return neg ? -quo[OUT_BITS-1:0] : quo[OUT_BITS-1:0];
  endfunction

  // Fit over the current sums, exact at 128 bits.
  function automatic fit_result_t fit_line();
    logic signed [127:0] n;
    logic signed [127:0] sx;
    logic signed [127:0] sy;
    logic signed [127:0] sxy;
    logic signed [127:0] sxx;
    logic signed [127:0] den;
    fit_result_t         r;
    n           = pt_count;
    sx          = sum_x;
    sy          = sum_y;
    sxy         = sum_xy;
    sxx         = sum_xx;
    r.slope     = '0;
    r.intercept = '0;
    r.status    = FS_OK;
    if (fit_origin) begin
      if (pt_count < 1) r.status = FS_TOO_FEW;
      else if (sum_xx == 0) r.status = FS_DEGENERATE;
      else r.slope = q16_quotient(sxy, sxx);
    end else if (pt_count < 2) begin
      r.status = FS_TOO_FEW;
    end else begin
      den = n * sxx - sx * sx;
      if (den == 0) begin
        r.status = FS_DEGENERATE;
      end else begin
        r.slope     = q16_quotient(n * sxy - sx * sy, den);
        r.intercept = q16_quotient(sy * sxx - sx * sxy, den);
      end
    end
    if (r.status == FS_OK && pts_dropped) r.status = FS_TOO_MANY;
    return r;
  endfunction

  // Idle lengths: mostly short gaps, now and then a long stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic signed [15:0] extreme_sample();
    case ($urandom_range(0, 3))
      0:       return S_MIN;
      1:       return S_MIN + 16'sd1;
      2:       return S_MAX - 16'sd1;
      default: return S_MAX;
    endcase
  endfunction

  // Offers one point and waits for its transfer. Valid stays high when the next
  // point follows at once, so it is never lowered and raised in the same step.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input bit last);
    int gap;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (pt_count < MAX_PTS) begin
      sum_x  += longint'(x);
      sum_y  += longint'(y);
      sum_xy += longint'(x) * longint'(y);
      sum_xx += longint'(x) * longint'(x);
      pt_count++;
    end else begin
      pts_dropped = 1'b1;
    end
    if (last) begin
      pending_fits = {pending_fits, fit_line()};
      pt_count    = 0;
      sum_x       = 0;
      sum_y       = 0;
      sum_xy      = 0;
      sum_xx      = 0;
      pts_dropped = 1'b0;
    end
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering points and waits until every fit has come back and the
  // block has finished any point still in flight.
  task automatic wait_fits_drained();
    in_tvalid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (POINT_SETTLE) @(posedge clk);
  endtask

  task automatic set_fit_mode(input bit origin);
    wait_fits_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= origin;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    fit_origin = origin;
  endtask

  task automatic test_too_few_points();
    set_fit_mode(1'b0);
    send_point(S_MAX, S_MIN, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b1);
  endtask

  // Steepest possible lines, full-scale swings and one exact line.
  task automatic test_extreme_lines();
    set_fit_mode(1'b0);
    send_point(S_MIN, S_MIN, 1'b0);
    send_point(S_MIN + 16'sd1, S_MAX, 1'b1);
    send_point(S_MAX, S_MAX, 1'b0);
    send_point(S_MIN, S_MIN, 1'b1);
    send_point(S_MAX - 16'sd1, S_MIN, 1'b0);
    send_point(S_MAX, S_MAX, 1'b1);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sd1, 16'sd3, 1'b0);
    send_point(16'sd2, 16'sd5, 1'b1);
  endtask

  // All x equal in line mode, all x zero through the origin.
  task automatic test_degenerate_x();
    set_fit_mode(1'b0);
    send_point(16'sd5, 16'sd1, 1'b0);
    send_point(16'sd5, -16'sd3, 1'b0);
    send_point(16'sd5, 16'sd9, 1'b1);
    set_fit_mode(1'b1);
    send_point(16'sd0, 16'sd100, 1'b0);
    send_point(16'sd0, -16'sd7, 1'b1);
  endtask

  task automatic test_origin_fit();
    set_fit_mode(1'b1);
    send_point(S_MIN, S_MAX, 1'b1);
    send_point(16'sd1, S_MIN, 1'b0);
    send_point(-16'sd1, S_MAX, 1'b1);
  endtask

  // One set that runs past the point limit with full-scale samples, so the
  // sums reach their widest values and the last two points are dropped.
  task automatic test_point_overflow();
    int i;
    set_fit_mode(1'b0);
    for (i = 0; i < MAX_PTS + 2; i++) begin
      send_point(extreme_sample(), extreme_sample(), i == MAX_PTS + 1);
    end
  endtask

  // The receiver holds off for a long stretch while short sets keep coming, so
  // the output register fills, the next fit waits behind it and input stalls.
  task automatic test_output_backpressure();
    int s;
    int i;
    int size;
    set_fit_mode(1'b0);
    calm         = 1'b1;
    hold_request = 4000;
    for (s = 0; s < 5; s++) begin
      size = $urandom_range(2, 3);
      for (i = 0; i < size; i++) begin
        send_point(16'($urandom), 16'($urandom), i == size - 1);
      end
    end
    wait_fits_drained();
    calm = 1'b0;
  endtask

  // Random sets in phases that alternate the fit mode. Most sets are short, with
  // random, small, extreme or near-linear points; a few are single points or degenerate.
  task automatic test_random_sets();
    int phase;
    int phase_sent;
    int size;
    int style;
    int i;
    int r;
    int m;
    int c;
    int xi;
    logic signed [15:0] cx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_fit_mode(phase[0]);
      calm       = (phase % 4 == 3);
      phase_sent = 0;
      while (phase_sent < RANDOM_POINTS / RANDOM_PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 8) size = 1;
        else if (r < 88) size = $urandom_range(2, 8);
        else size = $urandom_range(9, 40);
        r = $urandom_range(0, 9);
        if (r < 3) style = 0;
        else if (r < 5) style = 1;
        else if (r < 6) style = 2;
        else if (r < 7) style = 3;
        else if (r < 9) style = 4;
        else style = 5;
        cx = 16'($urandom);
        m  = int'($urandom_range(0, 100)) - 50;
        c  = int'($urandom_range(0, 2000)) - 1000;
        for (i = 0; i < size; i++) begin
          case (style)
            0: begin
              x = 16'($urandom);
              y = 16'($urandom);
            end
            1: begin
              x = 16'(int'($urandom_range(0, 16)) - 8);
              y = 16'(int'($urandom_range(0, 16)) - 8);
            end
            2: begin
              x = cx;
              y = 16'($urandom);
            end
            3: begin
              x = extreme_sample();
              y = extreme_sample();
            end
            4: begin
              xi = int'($urandom_range(0, 200)) - 100;
              x  = 16'(xi);
              y  = 16'(m * xi + c + int'($urandom_range(0, 6)) - 3);
            end
            default: begin
              x = 16'sd0;
              y = 16'($urandom);
            end
          endcase
          send_point(x, y, i == size - 1);
        end
        phase_sent += size;
        // Now and then the sender pauses until every fit has been delivered.
        if ($urandom_range(0, 9) == 0) wait_fits_drained();
      end
    end
    calm = 1'b0;
  endtask

  // Result side: a random ready pattern, or a long hold-off on request.
  always @(posedge clk) begin : drive_ready
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) stall_left = idle_len();
    end
  end

  // Every result transfer is matched against the oldest predicted fit.
  always @(posedge clk) begin : check_fit
    fit_result_t expected;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fits.size() == 0) begin
        $error("unexpected fit result: slope %0d intercept %0d status %0d",
               $signed(out_tdata[OUT_BITS-1:0]), $signed(out_tdata[2*OUT_BITS-1:OUT_BITS]),
               out_tuser);
        errors++;
      end else begin
        expected = pending_fits.pop_front();
        if (out_tdata[OUT_BITS-1:0] !== expected.slope) begin
          $error("slope: expected %0d, got %0d", expected.slope,
                 $signed(out_tdata[OUT_BITS-1:0]));
          errors++;
        end
        if (out_tdata[2*OUT_BITS-1:OUT_BITS] !== expected.intercept) begin
          $error("intercept: expected %0d, got %0d", expected.intercept,
                 $signed(out_tdata[2*OUT_BITS-1:OUT_BITS]));
          errors++;
        end
        if (out_tuser !== expected.status) begin
          $error("fit_status: expected %0d, got %0d", expected.status, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_too_few_points();
    test_extreme_lines();
    test_degenerate_x();
    test_origin_fit();
    test_point_overflow();
    test_output_backpressure();
    test_random_sets();
    wait_fits_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
sv/lsfit_pkg.sv
sv/least_squares_line_fit.sv
tb/tb_least_squares_line_fit.sv
